@@ sv/ethernet_ipv4_udp_header_parser_top_defines.svh @@
// ----------------------------------------------------------------------------
// Ethernet IPv4 UDP header parser - assertion macros
// Shared concurrent assertion forms for the parser's checks
// ----------------------------------------------------------------------------
`ifndef ETHERNET_IPV4_UDP_HEADER_PARSER_TOP_DEFINES_SVH
`define ETHERNET_IPV4_UDP_HEADER_PARSER_TOP_DEFINES_SVH

// checked at every rising clock edge outside reset
`define EIUHP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every rising clock edge, reset included
`define EIUHP_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/eiuhp_pkg.sv @@
// ----------------------------------------------------------------------------
// Ethernet IPv4 UDP header parser - package
// Protocol constants and the result record shared by the parser modules
// ----------------------------------------------------------------------------
`default_nettype none

package eiuhp_pkg;

  localparam logic [15:0] VLAN_TYPE = 16'h8100;
  localparam logic [15:0] IPV4_TYPE = 16'h0800;
  localparam logic [7:0]  UDP_PROTO = 8'd17;

  // ip header offset without and with one 802.1q tag
  localparam logic [4:0]  IP_START_PLAIN = 5'd14;
  localparam logic [4:0]  IP_START_VLAN  = 5'd18;

  localparam logic [15:0] ETH_HDR_BYTES  = 16'd14;
  localparam logic [15:0] VLAN_HDR_BYTES = 16'd18;
  localparam logic [15:0] IPV4_MIN_BYTES = 16'd20;
  localparam logic [15:0] UDP_HDR_BYTES  = 16'd8;

  typedef struct packed {
    logic        malformed;
    logic [15:0] final_ethertype;
    logic        is_ipv4;
    logic        is_udp;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [15:0] udp_payload_length;
  } result_t;

endpackage

`default_nettype wire

@@ sv/eiuhp_core.sv @@
// ----------------------------------------------------------------------------
// Ethernet IPv4 UDP header parser - capture core
// Per-byte header capture state and the end-of-frame result decode
// ----------------------------------------------------------------------------
`default_nettype none

module eiuhp_core #(
  parameter int unsigned MAX_FRAME_BYTES = 65535
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire logic [7:0]        frame_byte_i,
  input  wire logic              frame_end_i,
  output eiuhp_pkg::result_t     res_o
);
  import eiuhp_pkg::*;

  localparam logic [15:0] MaxPos = 16'(MAX_FRAME_BYTES);

  logic [15:0] pos_q, pos_d;
  logic [15:0] tw_q, tw_d;
  logic        vlan_q, vlan_d;
  logic [3:0]  hw_q, hw_d;
  logic [7:0]  proto_q, proto_d;
  logic [31:0] src_q, src_d;
  logic [31:0] dst_q, dst_d;
  logic [7:0]  pl_q [6];
  logic [7:0]  pl_d [6];

  // state after this byte is taken
  logic        take;
  logic [15:0] tw1, tw2;
  logic        vlan1;
  logic [4:0]  ip_start1;
  logic        in_ip;
  logic [15:0] rel;
  logic [3:0]  hw1;
  logic [7:0]  proto1;
  logic [31:0] src1, dst1;
  logic [6:0]  udp_start;
  logic [15:0] udp_off;
  logic        in_udp;
  logic [7:0]  pl1 [6];
  logic [15:0] cnt1;
  logic [15:0] ulen;
  logic        bad, ipv4, udp;

  always_comb begin
    take = step_i && (pos_q < MaxPos);

    tw1 = tw_q;
    if (take && (pos_q == 16'd12 || pos_q == 16'd13)) begin
      tw1 = {tw_q[7:0], frame_byte_i};
    end
    vlan1 = vlan_q;
    if (take && pos_q == 16'd13) begin
      vlan1 = (tw1 == VLAN_TYPE);
    end
    tw2 = tw1;
    if (take && vlan1 && (pos_q == 16'd16 || pos_q == 16'd17)) begin
      tw2 = {tw1[7:0], frame_byte_i};
    end

    ip_start1 = vlan1 ? IP_START_VLAN : IP_START_PLAIN;
    in_ip     = take && (pos_q >= {11'd0, ip_start1});
    rel       = pos_q - {11'd0, ip_start1};

    hw1 = hw_q;
    if (in_ip && rel == 16'd0) begin
      hw1 = frame_byte_i[3:0];
    end
    proto1 = proto_q;
    if (in_ip && rel == 16'd9) begin
      proto1 = frame_byte_i;
    end
    src1 = src_q;
    if (in_ip && rel >= 16'd12 && rel < 16'd16) begin
      src1 = {src_q[23:0], frame_byte_i};
    end
    dst1 = dst_q;
    if (in_ip && rel >= 16'd16 && rel < 16'd20) begin
      dst1 = {dst_q[23:0], frame_byte_i};
    end

    // udp header follows the ip header, using the length just seen
    udp_start = {2'd0, ip_start1} + {1'b0, hw1, 2'b00};
    udp_off   = pos_q - {9'd0, udp_start};
    in_udp    = in_ip && (pos_q >= {9'd0, udp_start}) && (udp_off < 16'd6);
    for (int i = 0; i < 6; i++) begin
      pl1[i] = pl_q[i];
      if (in_udp && udp_off[2:0] == 3'(i)) begin
        pl1[i] = frame_byte_i;
      end
    end

    cnt1 = take ? pos_q + 16'd1 : pos_q;

    // end-of-frame decode
    ipv4 = 1'b0;
    udp  = 1'b0;
    bad  = 1'b0;
    if (cnt1 < ETH_HDR_BYTES) begin
      bad = 1'b1;
    end else if (vlan1 && cnt1 < VLAN_HDR_BYTES) begin
      bad = 1'b1;
    end else if (tw2 == IPV4_TYPE) begin
      if (cnt1 < {11'd0, ip_start1} + IPV4_MIN_BYTES) begin
        bad = 1'b1;
      end else begin
        ipv4 = 1'b1;
        if (proto1 == UDP_PROTO) begin
          if (cnt1 < {9'd0, udp_start} + UDP_HDR_BYTES) begin
            bad = 1'b1;
          end else begin
            udp = 1'b1;
          end
        end
      end
    end

    ulen = {pl1[4], pl1[5]};
    res_o = '0;
    if (bad) begin
      res_o.malformed = 1'b1;
    end else begin
      res_o.final_ethertype = tw2;
      res_o.is_ipv4         = ipv4;
      res_o.is_udp          = udp;
      if (ipv4) begin
        res_o.source_address = src1;
        res_o.dest_address   = dst1;
      end
      if (udp) begin
        res_o.source_port        = {pl1[0], pl1[1]};
        res_o.dest_port          = {pl1[2], pl1[3]};
        res_o.udp_payload_length = (ulen >= UDP_HDR_BYTES) ? ulen - UDP_HDR_BYTES : 16'd0;
      end
    end
  end

  always_comb begin
    pos_d   = pos_q;
    tw_d    = tw_q;
    vlan_d  = vlan_q;
    hw_d    = hw_q;
    proto_d = proto_q;
    src_d   = src_q;
    dst_d   = dst_q;
    for (int i = 0; i < 6; i++) begin
      pl_d[i] = pl_q[i];
    end
    if (step_i && frame_end_i) begin
      // frame done, back to the reset picture
      pos_d   = '0;
      tw_d    = '0;
      vlan_d  = 1'b0;
      hw_d    = '0;
      proto_d = '0;
      src_d   = '0;
      dst_d   = '0;
      for (int i = 0; i < 6; i++) begin
        pl_d[i] = '0;
      end
    end else if (step_i) begin
      pos_d   = cnt1;
      tw_d    = tw2;
      vlan_d  = vlan1;
      hw_d    = hw1;
      proto_d = proto1;
      src_d   = src1;
      dst_d   = dst1;
      for (int i = 0; i < 6; i++) begin
        pl_d[i] = pl1[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      tw_q    <= '0;
      vlan_q  <= 1'b0;
      hw_q    <= '0;
      proto_q <= '0;
      src_q   <= '0;
      dst_q   <= '0;
      for (int i = 0; i < 6; i++) begin
        pl_q[i] <= '0;
      end
    end else begin
      pos_q   <= pos_d;
      tw_q    <= tw_d;
      vlan_q  <= vlan_d;
      hw_q    <= hw_d;
      proto_q <= proto_d;
      src_q   <= src_d;
      dst_q   <= dst_d;
      for (int i = 0; i < 6; i++) begin
        pl_q[i] <= pl_d[i];
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/ethernet_ipv4_udp_header_parser_top.sv @@
// ----------------------------------------------------------------------------
// Ethernet IPv4 UDP header parser - top level
// Byte-stream parser for ethernet / 802.1q / ipv4 / udp headers, one result
// item per frame
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 payload
//  --------  ---------  ------------------------  ----------------------------
//  in        sink       in_valid_i / in_stall_o   frame_byte_i, frame_end_i
//  out       source     out_valid_o / out_stall_i malformed_o .. udp_payload_length_o
//
//  one byte item accepted per cycle while in_stall_o is low; a frame result leaves
//  after its end-marked byte is accepted (input register, then result register)
//  reset clears the capture state to an empty frame and empties both stages
//  a stalled result holds the result register; the input stage still fills,
//  and in_stall_o rises only when both stages hold an item and out is stalled
// ----------------------------------------------------------------------------
`default_nettype none

`include "ethernet_ipv4_udp_header_parser_top_defines.svh"

module ethernet_ipv4_udp_header_parser_top #(
  parameter int unsigned MAX_FRAME_BYTES = 65535
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  frame_byte_i,
  input  wire logic        frame_end_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             malformed_o,
  output logic [15:0]      final_ethertype_o,
  output logic             is_ipv4_o,
  output logic             is_udp_o,
  output logic [31:0]      source_address_o,
  output logic [31:0]      dest_address_o,
  output logic [15:0]      source_port_o,
  output logic [15:0]      dest_port_o,
  output logic [15:0]      udp_payload_length_o
);
  import eiuhp_pkg::*;

  // input register stage
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_end_q;

  // result register stage
  logic       out_valid_q, out_valid_d;
  result_t    out_res_q;
  result_t    core_res;

  logic       out_free;   // result register can take a new value this cycle
  logic       advance;    // input register can take a new item this cycle
  logic       step;       // byte in the input register is consumed

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = !s1_valid_q || out_free;
  assign step       = s1_valid_q && out_free;
  assign in_stall_o = !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_byte_q <= frame_byte_i;
      s1_end_q  <= frame_end_i;
    end
  end

  // per-byte capture and the frame decode
  eiuhp_core #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .frame_byte_i (s1_byte_q),
    .frame_end_i  (s1_end_q),
    .res_o        (core_res)
  );

  // a result item is produced only on the end-marked byte
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = step && s1_end_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && s1_end_q) begin
      out_res_q <= core_res;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign malformed_o          = out_res_q.malformed;
  assign final_ethertype_o    = out_res_q.final_ethertype;
  assign is_ipv4_o            = out_res_q.is_ipv4;
  assign is_udp_o             = out_res_q.is_udp;
  assign source_address_o     = out_res_q.source_address;
  assign dest_address_o       = out_res_q.dest_address;
  assign source_port_o        = out_res_q.source_port;
  assign dest_port_o          = out_res_q.dest_port;
  assign udp_payload_length_o = out_res_q.udp_payload_length;

  // input side only backs up when both stages are full and out is stalled
  `EIUHP_ASSERT(a_stall_only_when_full, clk_i, rst_ni, in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i), "in_stall_o raised with room in the pipeline")

  // a consumed end-marked byte always yields a result item next cycle
  `EIUHP_ASSERT(a_end_gives_result, clk_i, rst_ni, (step && s1_end_q) |=> out_valid_o, "end-marked item produced no result")

  // a malformed result carries nothing else
  `EIUHP_ASSERT(a_malformed_clean, clk_i, rst_ni, (out_valid_o && malformed_o) |-> (final_ethertype_o == 16'd0 && !is_ipv4_o && !is_udp_o && source_address_o == 32'd0 && dest_port_o == 16'd0), "malformed result with nonzero fields")

  // udp is only reported inside a well-formed ipv4 frame
  `EIUHP_ASSERT_ALWAYS(a_udp_in_ipv4, clk_i, (out_valid_o && is_udp_o) |-> (is_ipv4_o && !malformed_o && final_ethertype_o == IPV4_TYPE), "udp flagged outside ipv4")

endmodule

`default_nettype wire
